// ----- src/pcp_pkg.sv -----
`timescale 1ns / 1ps

package pcp_pkg;

  // search limits
  localparam int unsigned MEM_CORE_KMAX = 3;
  localparam int unsigned SCAN_KMAX     = 7;
  localparam int unsigned NLANE         = 7;
  localparam int unsigned QBITS         = 7;

  // widths
  localparam int unsigned OSC_W   = 17;
  localparam int unsigned TGT_W   = 18;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned SH_W    = STEP_W + 6;
  localparam int unsigned VCO_W   = TGT_W + NLANE;
  localparam int unsigned KF_W    = 3;
  localparam int unsigned N_W     = 6;
  localparam int unsigned PADDR_W = 3;

  // pipeline depth
  localparam int unsigned SRCH_STG = 5;
  localparam int unsigned NSTG     = 2 * SRCH_STG + 2;

  // constants
  localparam logic [OSC_W-1:0] OSC_RESET = 17'd10000;
  localparam logic [TGT_W-1:0] MEM_CAP   = 18'd166000;
  localparam logic [TGT_W-1:0] CORE_CAP  = 18'd120000;
  localparam logic [TGT_W-1:0] SCAN_CAP  = 18'd100000;
  localparam logic [VCO_W-1:0] VCO_MIN   = 25'd100000;
  localparam logic [VCO_W-1:0] VCO_MAX   = 25'd600000;
  localparam logic [QBITS-1:0] MULT_MIN  = 7'd2;
  localparam logic [QBITS-1:0] MULT_MAX  = 7'd64;
  localparam logic [9:0]       KHZ_PER_MHZ = 10'd1000;

  // register index
  localparam logic REG_OSC = 1'b0;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_NO_MEM         = 3'd1,
    ST_NO_CORE        = 3'd2,
    ST_NO_SCAN        = 3'd3,
    ST_CORE_ABOVE_MEM = 3'd4,
    ST_CORE_LOW       = 3'd5,
    ST_CORE_SCAN      = 3'd6
  } status_e;

  typedef struct packed {
    logic             found;
    logic [KF_W-1:0]  k;
    logic [N_W-1:0]   n;
    logic [TGT_W-1:0] freq;
  } pick_t;

  typedef struct packed {
    logic [TGT_W-1:0] rem;
    logic [TGT_W-1:0] acc;
    logic [QBITS-1:0] q;
    logic             ovf;
  } div_t;

  // one restoring division step for quotient bit b
  function automatic div_t div_bit(div_t d, logic [STEP_W-1:0] step, int unsigned b);
    logic [SH_W-1:0] sh;
    div_t r;
    sh = SH_W'(step) << b;
    r  = d;
    if (SH_W'(d.rem) >= sh) begin
      r.rem = d.rem - TGT_W'(sh);
      r.acc = d.acc + TGT_W'(sh);
      r.q   = d.q | (QBITS'(1) << b);
    end
    return r;
  endfunction

endpackage

// ----- src/pcp_req_if.sv -----
`timescale 1ns / 1ps

interface pcp_req_if;
  logic        valid;
  logic        ready;
  logic [9:0]  mem_speed_mhz;
  logic [17:0] dot_clock_khz;

  modport source (output valid, output mem_speed_mhz, output dot_clock_khz, input ready);
  modport sink   (input valid, input mem_speed_mhz, input dot_clock_khz, output ready);
endinterface

// ----- src/pcp_rsp_if.sv -----
`timescale 1ns / 1ps

interface pcp_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  mem_k;
  logic [5:0]  mem_n;
  logic [17:0] mem_freq_khz;
  logic [1:0]  core_k;
  logic [5:0]  core_n;
  logic [16:0] core_freq_khz;
  logic [2:0]  scan_k;
  logic [5:0]  scan_n;
  logic [16:0] scan_freq_khz;

  modport source (output valid, output status, output mem_k, output mem_n,
                  output mem_freq_khz, output core_k, output core_n, output core_freq_khz,
                  output scan_k, output scan_n, output scan_freq_khz, input ready);
  modport sink   (input valid, input status, input mem_k, input mem_n,
                  input mem_freq_khz, input core_k, input core_n, input core_freq_khz,
                  input scan_k, input scan_n, input scan_freq_khz, output ready);
endinterface

// ----- src/pll_clock_planner_top.sv -----
`timescale 1ns / 1ps
// channel | dir | handshake   | payload
// req     | in  | valid/ready | mem_speed_mhz, dot_clock_khz
// rsp     | out | valid/ready | status, mem/core/scan k, n, freq_khz
// apb     | in  | psel/penable/pwrite, pready always high | osc_khz at 0x0
//
// 12-stage pipeline, one item per cycle unless back-pressure on rsp stalls it
// each search is 4 division stages (7 quotient bits in all) and 1 select stage
// memory and scan searches run side by side, core search follows memory
// valid bits travel with data; a stage loads when it is empty or drains
// reset clears valid bits and sets osc_khz to 10000

module pll_clock_planner_top import pcp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  pcp_req_if.sink            req,
  pcp_rsp_if.source          rsp,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);

  logic [OSC_W-1:0] osc_q;
  logic [NSTG-1:0]  v_q;
  logic [NSTG-1:0]  en;
  logic [19:0]      mem_prod;
  logic [TGT_W-1:0] mem_t_d, scan_t_d, core_t;
  logic [TGT_W-1:0] mem_t_q, scan_t_q;
  pick_t            mem_pick, scan_pick, core_pick;
  pick_t            mem_dly_q  [SRCH_STG];
  pick_t            scan_dly_q [SRCH_STG];
  pick_t            mem_o_d, core_o_d, scan_o_d;
  pick_t            mem_o_q, core_o_q, scan_o_q;
  status_e          status_d, status_q;
  logic [TGT_W:0]   core_x2, scan_x15;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_q <= OSC_RESET;
    end else if (psel_i && penable_i && pwrite_i && paddr_i[2] == REG_OSC) begin
      osc_q <= pwdata_i[OSC_W-1:0];
    end
  end

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_OSC) ? 32'(osc_q) : '0;

  // stage enables, a stage moves when empty or when the next one moves
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || rsp.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign req.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= req.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // capped targets
  assign mem_prod = 20'(req.mem_speed_mhz) * 20'(KHZ_PER_MHZ);
  assign mem_t_d  = (mem_prod > 20'(MEM_CAP)) ? MEM_CAP : TGT_W'(mem_prod);
  assign scan_t_d = (req.dot_clock_khz > SCAN_CAP) ? SCAN_CAP : req.dot_clock_khz;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mem_t_q  <= mem_t_d;
      scan_t_q <= scan_t_d;
    end
  end

  // memory and scan searches
  pcp_search u_mem (
    .clk_i    (clk_i),
    .en_i     (en[SRCH_STG:1]),
    .osc_i    (osc_q),
    .kmax_i   (3'(MEM_CORE_KMAX)),
    .target_i (mem_t_q),
    .pick_o   (mem_pick)
  );

  pcp_search u_scan (
    .clk_i    (clk_i),
    .en_i     (en[SRCH_STG:1]),
    .osc_i    (osc_q),
    .kmax_i   (3'(SCAN_KMAX)),
    .target_i (scan_t_q),
    .pick_o   (scan_pick)
  );

  // core search from the memory result
  assign core_t = (mem_pick.freq > CORE_CAP) ? CORE_CAP : mem_pick.freq;

  pcp_search u_core (
    .clk_i    (clk_i),
    .en_i     (en[2*SRCH_STG:SRCH_STG+1]),
    .osc_i    (osc_q),
    .kmax_i   (3'(MEM_CORE_KMAX)),
    .target_i (core_t),
    .pick_o   (core_pick)
  );

  // memory and scan picks ride along with the core search
  always_ff @(posedge clk_i) begin
    if (en[SRCH_STG+1]) begin
      mem_dly_q[0]  <= mem_pick;
      scan_dly_q[0] <= scan_pick;
    end
    for (int i = 1; i < SRCH_STG; i++) begin
      if (en[SRCH_STG+1+i]) begin
        mem_dly_q[i]  <= mem_dly_q[i-1];
        scan_dly_q[i] <= scan_dly_q[i-1];
      end
    end
  end

  // status and clearing of later plls after a failed search
  assign core_x2  = {core_pick.freq, 1'b0};
  assign scan_x15 = (TGT_W+1)'(scan_dly_q[SRCH_STG-1].freq)
                  + (TGT_W+1)'(scan_dly_q[SRCH_STG-1].freq >> 1);

  always_comb begin
    mem_o_d  = mem_dly_q[SRCH_STG-1];
    scan_o_d = scan_dly_q[SRCH_STG-1];
    core_o_d = core_pick;
    status_d = ST_OK;
    priority if (!mem_o_d.found) begin
      status_d = ST_NO_MEM;
      mem_o_d  = '0;
      core_o_d = '0;
      scan_o_d = '0;
    end else if (!core_o_d.found) begin
      status_d = ST_NO_CORE;
      core_o_d = '0;
      scan_o_d = '0;
    end else if (!scan_o_d.found) begin
      status_d = ST_NO_SCAN;
      scan_o_d = '0;
    end else if (core_o_d.freq > mem_o_d.freq) begin
      status_d = ST_CORE_ABOVE_MEM;
    end else if (core_x2 <= (TGT_W+1)'(mem_o_d.freq)) begin
      status_d = ST_CORE_LOW;
    end else if ((TGT_W+1)'(core_o_d.freq) <= scan_x15) begin
      status_d = ST_CORE_SCAN;
    end else begin
      status_d = ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      status_q <= status_d;
      mem_o_q  <= mem_o_d;
      core_o_q <= core_o_d;
      scan_o_q <= scan_o_d;
    end
  end

  assign rsp.valid         = v_q[NSTG-1];
  assign rsp.status        = status_q;
  assign rsp.mem_k         = mem_o_q.k[1:0];
  assign rsp.mem_n         = mem_o_q.n;
  assign rsp.mem_freq_khz  = mem_o_q.freq;
  assign rsp.core_k        = core_o_q.k[1:0];
  assign rsp.core_n        = core_o_q.n;
  assign rsp.core_freq_khz = core_o_q.freq[16:0];
  assign rsp.scan_k        = scan_o_q.k;
  assign rsp.scan_n        = scan_o_q.n;
  assign rsp.scan_freq_khz = scan_o_q.freq[16:0];

  // checks
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> v_q[0])
    else $error("accepted item did not enter the pipeline");

  a_ok_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status == ST_OK |-> 18'(rsp.core_freq_khz) <= rsp.mem_freq_khz)
    else $error("ok status with core above memory");

  a_no_mem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status == ST_NO_MEM |-> rsp.mem_freq_khz == '0
      && rsp.core_freq_khz == '0 && rsp.scan_freq_khz == '0)
    else $error("failed memory search left nonzero fields");

  a_mem_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> rsp.mem_freq_khz <= MEM_CAP)
    else $error("memory frequency above cap");

endmodule

// ----- src/pcp_search.sv -----
`timescale 1ns / 1ps

module pcp_search import pcp_pkg::*; (
  input  logic                clk_i,
  input  logic [SRCH_STG-1:0] en_i,
  input  logic [OSC_W-1:0]    osc_i,
  input  logic [2:0]          kmax_i,
  input  logic [TGT_W-1:0]    target_i,
  output pick_t               pick_o
);

  logic [STEP_W-1:0] step   [NLANE];
  logic              elig   [NLANE];
  div_t              s1_d   [NLANE];
  div_t              s2_d   [NLANE];
  div_t              s3_d   [NLANE];
  div_t              s4_div [NLANE];
  logic              cand_d [NLANE];
  div_t              s1_q   [NLANE];
  div_t              s2_q   [NLANE];
  div_t              s3_q   [NLANE];
  logic              cand_q [NLANE];
  logic [TGT_W-1:0]  err_q  [NLANE];
  logic [TGT_W-1:0]  freq_q [NLANE];
  logic [QBITS-1:0]  mult_q [NLANE];
  pick_t             pick_d;
  pick_t             pick_q;

  // per-lane step and eligibility of exponent k = lane + 1
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      step[l] = STEP_W'(osc_i >> (l + 1));
      elig[l] = (3'(l + 1) <= kmax_i)
             && ((osc_i & OSC_W'((1 << (l + 1)) - 1)) == '0)
             && (step[l] != '0);
    end
  end

  // division lanes, two quotient bits per stage, one bit in the last division stage
  always_comb begin
    div_t d0;
    logic [VCO_W-1:0] vco;
    for (int l = 0; l < NLANE; l++) begin
      d0.rem = target_i;
      d0.acc = '0;
      d0.q   = '0;
      d0.ovf = SH_W'(target_i) >= ((SH_W'(step[l]) << 6) + SH_W'(step[l]));
      s1_d[l]   = div_bit(div_bit(d0, step[l], 6), step[l], 5);
      s2_d[l]   = div_bit(div_bit(s1_q[l], step[l], 4), step[l], 3);
      s3_d[l]   = div_bit(div_bit(s2_q[l], step[l], 2), step[l], 1);
      s4_div[l] = div_bit(s3_q[l], step[l], 0);
      vco       = VCO_W'(s4_div[l].acc) << (l + 1);
      cand_d[l] = elig[l] && !s4_div[l].ovf
               && (s4_div[l].q >= MULT_MIN) && (s4_div[l].q <= MULT_MAX)
               && (vco >= VCO_MIN) && (vco <= VCO_MAX);
    end
  end

  // smallest shortfall wins, lower k on a tie
  always_comb begin
    logic [TGT_W-1:0] best;
    best   = '0;
    pick_d = '0;
    for (int l = 0; l < NLANE; l++) begin
      if (cand_q[l] && (!pick_d.found || err_q[l] < best)) begin
        best         = err_q[l];
        pick_d.found = 1'b1;
        pick_d.k     = KF_W'(l + 1);
        pick_d.n     = N_W'(mult_q[l] - QBITS'(1));
        pick_d.freq  = freq_q[l];
      end
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NLANE; l++) begin
      if (en_i[0]) s1_q[l] <= s1_d[l];
      if (en_i[1]) s2_q[l] <= s2_d[l];
      if (en_i[2]) s3_q[l] <= s3_d[l];
      if (en_i[3]) begin
        cand_q[l] <= cand_d[l];
        err_q[l]  <= s4_div[l].rem;
        freq_q[l] <= s4_div[l].acc;
        mult_q[l] <= s4_div[l].q;
      end
    end
    if (en_i[4]) pick_q <= pick_d;
  end

  assign pick_o = pick_q;

endmodule
